// ===== rtl/selective_repeat_reorder_receiver_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the selective-repeat reorder receiver
// Shared property shorthands used by the receiver's queue and engine.
// ---------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_REORDER_RECEIVER_UNIT_MACROS_SVH
`define SELECTIVE_REPEAT_REORDER_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define SRRR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srrr assertion failed");

// Next-cycle implication, off while reset is asserted.
`define SRRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srrr assertion failed");

`endif

// ===== rtl/srrr_pkg.sv =====
// ---------------------------------------------------------------------------
// srrr_pkg
// Widths, codes, the queued item type and the slot mapping of the receiver.
// ---------------------------------------------------------------------------
package srrr_pkg;

    localparam int WINDOW_SLOTS  = 8;
    localparam int PAYLOAD_BYTES = 1024;

    localparam int CMD_W = 2;
    localparam int SEQ_W = 32;
    localparam int LEN_W = 11;
    localparam int REF_W = 16;

    localparam int SLOT_W     = $clog2(WINDOW_SLOTS);
    localparam int BYTE_SHIFT = $clog2(PAYLOAD_BYTES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PAYLOAD_BYTES);

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIN   = 2'd2;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] plen;
        logic [REF_W-1:0] pref;
    } item_t;

    // Slot of a sequence number: (seq / PAYLOAD_BYTES) mod WINDOW_SLOTS.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SEQ_W-1:0] seq);
        return seq[BYTE_SHIFT +: SLOT_W];
    endfunction

endpackage

// ===== rtl/srrr_front.sv =====
// ---------------------------------------------------------------------------
// srrr_front
// Input stage: take a descriptor beat, clamp its length, drop unused codes.
// ---------------------------------------------------------------------------
module srrr_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [srrr_pkg::CMD_W-1:0]   command,
    input  logic [srrr_pkg::SEQ_W-1:0]   seq_number,
    input  logic [srrr_pkg::LEN_W-1:0]   payload_length,
    input  logic [srrr_pkg::REF_W-1:0]   payload_ref,
    output logic                         push_valid,
    input  logic                         push_ready,
    output srrr_pkg::item_t              push_item
);
    import srrr_pkg::*;

    logic  stage_valid_reg, stage_valid_next;
    item_t stage_item_reg;
    logic  take;
    logic  known_cmd;

    assign in_ready   = !stage_valid_reg || push_ready;
    assign take       = in_valid && in_ready;
    assign known_cmd  = (command == CMD_START) || (command == CMD_DATA) || (command == CMD_FIN);
    assign push_valid = stage_valid_reg;
    assign push_item  = stage_item_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = known_cmd;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Payload register: clamp oversize lengths on the way in.
    always_ff @(posedge clk)
    begin
        if (take && known_cmd)
        begin
            stage_item_reg.cmd  <= command;
            stage_item_reg.seq  <= seq_number;
            stage_item_reg.plen <= (payload_length > MAX_LEN) ? MAX_LEN : payload_length;
            stage_item_reg.pref <= payload_ref;
        end
    end

endmodule

// ===== rtl/srrr_queue.sv =====
// ---------------------------------------------------------------------------
// srrr_queue
// Short FIFO between the front stage and the execution engine.
// ---------------------------------------------------------------------------
`include "selective_repeat_reorder_receiver_unit_macros.svh"

module srrr_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  srrr_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output srrr_pkg::item_t pop_item
);
    import srrr_pkg::*;

    item_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push, pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `SRRR_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
    `SRRR_ASSERT_NEXT(a_push_counts, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `SRRR_ASSERT_IMPLY(a_ptr_agree, clk, rst_n, count_reg == '0 || count_reg == QUEUE_CNT_W'(QUEUE_DEPTH), wr_ptr_reg == rd_ptr_reg)

endmodule

// ===== rtl/srrr_back.sv =====
// ---------------------------------------------------------------------------
// srrr_back
// Execution engine: session state, reorder slots, drain and result register.
// ---------------------------------------------------------------------------
`include "selective_repeat_reorder_receiver_unit_macros.svh"

module srrr_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  srrr_pkg::item_t              pop_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         kind,
    output logic [srrr_pkg::REF_W-1:0]   out_ref,
    output logic [srrr_pkg::LEN_W-1:0]   out_length,
    output logic [srrr_pkg::SEQ_W-1:0]   ack_number,
    output logic                         last
);
    import srrr_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                    state_reg, state_next;
    logic [SEQ_W-1:0]        expected_reg, expected_next;
    logic                    open_reg, open_next;
    logic [WINDOW_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [REF_W-1:0]        slot_ref_reg [WINDOW_SLOTS];
    logic [LEN_W-1:0]        slot_len_reg [WINDOW_SLOTS];

    logic                    out_valid_reg, out_valid_next;
    logic                    kind_reg;
    logic [REF_W-1:0]        ref_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [SEQ_W-1:0]        ack_reg;
    logic                    last_reg;

    logic                    out_can, pop;
    logic                    emit, emit_kind, emit_last;
    logic [REF_W-1:0]        emit_ref;
    logic [LEN_W-1:0]        emit_len;
    logic [SEQ_W-1:0]        emit_ack;
    logic                    store_en;
    logic [SLOT_W-1:0]       store_idx, drain_idx;

    assign out_can   = !out_valid_reg || out_ready;
    assign pop_ready = (state_reg == ST_IDLE) && out_can;
    assign pop       = pop_valid && pop_ready;
    assign store_idx = slot_of(pop_item.seq);
    assign drain_idx = slot_of(expected_reg);

    always_comb
    begin
        state_next      = state_reg;
        expected_next   = expected_reg;
        open_next       = open_reg;
        slot_valid_next = slot_valid_reg;
        store_en        = 1'b0;
        emit            = 1'b0;
        emit_kind       = KIND_ACK;
        emit_ref        = '0;
        emit_len        = '0;
        emit_ack        = expected_reg;
        emit_last       = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    unique case (pop_item.cmd)
                        CMD_START:
                        begin
                            expected_next = pop_item.seq;
                            open_next     = 1'b1;
                            emit          = 1'b1;
                            emit_ack      = pop_item.seq;
                        end
                        CMD_DATA:
                        begin
                            if (open_reg)
                            begin
                                emit = 1'b1;
                                if (pop_item.seq == expected_reg)
                                begin
                                    // In order: deliver now, then drain.
                                    emit_kind     = KIND_DELIVER;
                                    emit_ref      = pop_item.pref;
                                    emit_len      = pop_item.plen;
                                    emit_ack      = '0;
                                    emit_last     = 1'b0;
                                    expected_next = expected_reg + SEQ_W'(pop_item.plen);
                                    state_next    = ST_DRAIN;
                                end
                                else if (pop_item.seq > expected_reg &&
                                         !slot_valid_reg[store_idx])
                                begin
                                    store_en                   = 1'b1;
                                    slot_valid_next[store_idx] = 1'b1;
                                end
                            end
                        end
                        CMD_FIN:
                        begin
                            open_next       = 1'b0;
                            slot_valid_next = '0;
                            emit            = 1'b1;
                            emit_ack        = pop_item.seq + 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (out_can)
                begin
                    emit = 1'b1;
                    if (slot_valid_reg[drain_idx])
                    begin
                        emit_kind                  = KIND_DELIVER;
                        emit_ref                   = slot_ref_reg[drain_idx];
                        emit_len                   = slot_len_reg[drain_idx];
                        emit_ack                   = '0;
                        emit_last                  = 1'b0;
                        expected_next              = expected_reg +
                                                     SEQ_W'(slot_len_reg[drain_idx]);
                        slot_valid_next[drain_idx] = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            expected_reg   <= '0;
            open_reg       <= 1'b0;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            expected_reg   <= expected_next;
            open_reg       <= open_next;
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            slot_ref_reg[store_idx] <= pop_item.pref;
            slot_len_reg[store_idx] <= pop_item.plen;
        end
        if (emit)
        begin
            kind_reg <= emit_kind;
            ref_reg  <= emit_ref;
            len_reg  <= emit_len;
            ack_reg  <= emit_ack;
            last_reg <= emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign out_ref    = ref_reg;
    assign out_length = len_reg;
    assign ack_number = ack_reg;
    assign last       = last_reg;

    `SRRR_ASSERT_IMPLY(a_drain_open, clk, rst_n, state_reg == ST_DRAIN, open_reg)
    `SRRR_ASSERT_NEXT(a_fin_clears, clk, rst_n, pop && pop_item.cmd == CMD_FIN, slot_valid_reg == '0 && !open_reg)
    `SRRR_ASSERT_IMPLY(a_last_is_ack, clk, rst_n, out_valid_reg, last_reg == (kind_reg == KIND_ACK))
    `SRRR_ASSERT_IMPLY(a_no_pop_in_drain, clk, rst_n, state_reg == ST_DRAIN, !pop)

endmodule

// ===== rtl/selective_repeat_reorder_receiver_unit.sv =====
// ---------------------------------------------------------------------------
// selective_repeat_reorder_receiver_unit
// Receive side of a selective-repeat transfer with an in-order reorder window.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one packet descriptor per beat:
//   command (start, data, fin), seq_number, payload_length, payload_ref.
//   Output channel (out_valid/out_ready) gives one result per beat: in-order
//   deliveries (kind 0) and then exactly one ack (kind 1, last high) per
//   packet. Data before a start and unused commands give no result.
//   The first result of a descriptor is registered in the front stage, then
//   in the queue and then in the engine's result register.
//   Start, fin, stored, duplicate and out-of-window data give their result
//   straight from the engine; an in-order data packet is delivered, then the
//   engine's drain loop walks the reorder slots, one slot per cycle while the
//   result register can take a result, then acks; it takes no new descriptor.
//   Reset clears the session, the expected sequence and all slot valid bits
//   at once; no clearing sweep is needed. When out_ready is low the result
//   register holds, the engine waits, the queue fills and then in_ready drops.
// ---------------------------------------------------------------------------
module selective_repeat_reorder_receiver_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [srrr_pkg::CMD_W-1:0]   command,
    input  logic [srrr_pkg::SEQ_W-1:0]   seq_number,
    input  logic [srrr_pkg::LEN_W-1:0]   payload_length,
    input  logic [srrr_pkg::REF_W-1:0]   payload_ref,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         kind,
    output logic [srrr_pkg::REF_W-1:0]   out_ref,
    output logic [srrr_pkg::LEN_W-1:0]   out_length,
    output logic [srrr_pkg::SEQ_W-1:0]   ack_number,
    output logic                         last
);
    import srrr_pkg::*;

    // Front stage to queue.
    logic  push_valid, push_ready;
    item_t push_item;

    // Queue to engine.
    logic  pop_valid, pop_ready;
    item_t pop_item;

    // Clamp lengths and drop unused commands before they reach the queue.
    srrr_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .seq_number     (seq_number),
        .payload_length (payload_length),
        .payload_ref    (payload_ref),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    // Decouple the front from the engine so each side stalls on its own.
    srrr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Run the session, store packets ahead of the expected sequence, drain and ack.
    srrr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .out_ref    (out_ref),
        .out_length (out_length),
        .ack_number (ack_number),
        .last       (last)
    );

endmodule

// ===== dv/tb_selective_repeat_reorder_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// tb_selective_repeat_reorder_receiver_unit
// Self-checking bench for the selective-repeat reorder receiver. A scripted
// opening walks reset behavior, clamping, slot collisions, drains, wrap and
// fin; random sessions of out-of-order packets follow under four idling
// profiles. Every result beat is compared with an in-bench reorder predictor.
// ----------------------------------------------------------------------------
module tb_selective_repeat_reorder_receiver_unit;

    import srrr_pkg::*;

    // Command code the block leaves unused; it must be swallowed silently.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Cycles with no beat on either channel before the run is declared hung.
    localparam int QUIET_LIMIT = 5000;
    // Cycles to keep watching the output once nothing more is expected.
    localparam int SETTLE_CYCLES = 40;
    // Length of the forced receiver hold-off in the first random phase.
    localparam int LONG_HOLD = 200;
    // Counted items per random phase (items that produce at least one result).
    localparam int ITEMS_PER_PHASE = 125;

    typedef struct packed {
        logic             kind;
        logic [REF_W-1:0] handle;
        logic [LEN_W-1:0] nbytes;
        logic [SEQ_W-1:0] ack;
        logic             last;
    } result_t;

    // One scripted packet. Rows with typed set carry their expected outcome
    // (zero or one ack); all other rows are checked against the predictor.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] nbytes;
        logic [REF_W-1:0] handle;
        logic             typed;
        logic [1:0]       n_typed;
        logic [SEQ_W-1:0] typed_ack;
    } script_row_t;

    localparam int N_SCRIPT = 22;

    script_row_t script [N_SCRIPT] = '{
        // data before any start: ignored
        '{CMD_DATA,   32'h0000_0000, 11'd100,  16'h0001, 1'b1, 2'd0, 32'h0},
        // unused command with every field at its top value: ignored
        '{CMD_UNUSED, 32'hFFFF_FFFF, 11'd2047, 16'hFFFF, 1'b1, 2'd0, 32'h0},
        // fin without a session, sequence wraps on the plus one
        '{CMD_FIN,    32'hFFFF_FFFF, 11'd0,    16'h0000, 1'b1, 2'd1, 32'h0},
        '{CMD_START,  32'h0000_0000, 11'd0,    16'h0000, 1'b1, 2'd1, 32'h0},
        // two packets ahead of expected go to slots 2 and 1
        '{CMD_DATA,   32'h0000_0800, 11'd1024, 16'hFFFF, 1'b1, 2'd1, 32'h0},
        '{CMD_DATA,   32'h0000_0400, 11'd1024, 16'h0002, 1'b1, 2'd1, 32'h0},
        // slot 2 already holds a packet: drop this one
        '{CMD_DATA,   32'h0000_0800, 11'd512,  16'h0003, 1'b1, 2'd1, 32'h0},
        // in order with an over-range length: clamp, then drain two slots
        '{CMD_DATA,   32'h0000_0000, 11'd2047, 16'h0000, 1'b0, 2'd0, 32'h0},
        // behind expected: duplicate
        '{CMD_DATA,   32'h0000_0005, 11'd10,   16'h0004, 1'b1, 2'd1, 32'h0C00},
        // zero-length packet parked in slot 4
        '{CMD_DATA,   32'h0000_1000, 11'd0,    16'h1234, 1'b1, 2'd1, 32'h0C00},
        // in order, drains the zero-length slot and stops
        '{CMD_DATA,   32'h0000_0C00, 11'd1024, 16'h0005, 1'b0, 2'd0, 32'h0},
        // parked in slot 0, survives the restart below
        '{CMD_DATA,   32'h0000_2000, 11'd1024, 16'h0006, 1'b0, 2'd0, 32'h0},
        // repeated start near the top of the sequence space
        '{CMD_START,  32'hFFFF_F800, 11'd0,    16'h0000, 1'b1, 2'd1, 32'hFFFF_F800},
        '{CMD_DATA,   32'hFFFF_FC00, 11'd1024, 16'h0007, 1'b1, 2'd1, 32'hFFFF_F800},
        // in order: drain across the wrap into the kept slot 0
        '{CMD_DATA,   32'hFFFF_F800, 11'd1024, 16'h0008, 1'b0, 2'd0, 32'h0},
        '{CMD_FIN,    32'h0000_04D2, 11'd0,    16'h0000, 1'b1, 2'd1, 32'h0000_04D3},
        // session closed: ignored
        '{CMD_DATA,   32'h0000_04D3, 11'd1,    16'h0009, 1'b1, 2'd0, 32'h0},
        '{CMD_START,  32'h8000_0000, 11'd0,    16'h0000, 1'b1, 2'd1, 32'h8000_0000},
        '{CMD_DATA,   32'h8000_0000, 11'd1023, 16'hAAAA, 1'b0, 2'd0, 32'h0},
        '{CMD_DATA,   32'h8000_0400, 11'd1024, 16'h5555, 1'b0, 2'd0, 32'h0},
        '{CMD_DATA,   32'h8000_03FF, 11'd1,    16'h0000, 1'b0, 2'd0, 32'h0},
        '{CMD_FIN,    32'h7FFF_FFFF, 11'd0,    16'h0000, 1'b1, 2'd1, 32'h8000_0000}
    };

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [CMD_W-1:0] command;
    logic [SEQ_W-1:0] seq_number;
    logic [LEN_W-1:0] payload_length;
    logic [REF_W-1:0] payload_ref;
    logic             out_valid;
    logic             out_ready;
    logic             kind;
    logic [REF_W-1:0] out_ref;
    logic [LEN_W-1:0] out_length;
    logic [SEQ_W-1:0] ack_number;
    logic             last;

    // Predictor state: expected sequence, session flag and the reorder window.
    logic [SEQ_W-1:0] next_seq;
    logic             session_up;
    logic             win_valid  [WINDOW_SLOTS];
    logic [REF_W-1:0] win_handle [WINDOW_SLOTS];
    logic [LEN_W-1:0] win_nbytes [WINDOW_SLOTS];

    result_t packet_results [$];   // results of the packet just accepted
    result_t awaited_results [$];  // results still due on the output channel
    result_t head;

    int  mismatches;
    int  counted_items;
    int  quiet_cycles;
    int  src_idle_pct;
    int  snk_stall_pct;
    int  sink_hold_left;

    selective_repeat_reorder_receiver_unit dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .seq_number     (seq_number),
        .payload_length (payload_length),
        .payload_ref    (payload_ref),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .out_ref        (out_ref),
        .out_length     (out_length),
        .ack_number     (ack_number),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Reorder predictor
    // ------------------------------------------------------------------------

    // Window slot owning a sequence number: which PAYLOAD_BYTES block it falls
    // in, folded onto the window.
    function automatic int window_slot(input logic [SEQ_W-1:0] seq);
        return int'((seq / PAYLOAD_BYTES) % WINDOW_SLOTS);
    endfunction

    function automatic void add_result(input logic k, input logic [REF_W-1:0] h,
                                       input logic [LEN_W-1:0] n,
                                       input logic [SEQ_W-1:0] a, input logic l);
        result_t r;
        r.kind   = k;
        r.handle = h;
        r.nbytes = n;
        r.ack    = a;
        r.last   = l;
        packet_results.push_back(r);
    endfunction

    // Apply one accepted packet to the predictor; leave its results in
    // packet_results and return how many there are.
    function automatic int reorder_and_ack(input logic [CMD_W-1:0] cmd,
                                           input logic [SEQ_W-1:0] seq,
                                           input logic [LEN_W-1:0] len_in,
                                           input logic [REF_W-1:0] handle);
        logic [LEN_W-1:0] len;
        int               s;
        packet_results.delete();
        len = (len_in > MAX_LEN) ? MAX_LEN : len_in;
        case (cmd)
            CMD_START:
            begin
                next_seq   = seq;
                session_up = 1'b1;
            end
            CMD_DATA:
            begin
                if (!session_up)
                    return 0;
                if (seq == next_seq)
                begin
                    // deliver, then drain while the slot of the new expected
                    // sequence holds a packet; clear each slot as it goes
                    add_result(KIND_DELIVER, handle, len, '0, 1'b0);
                    next_seq = next_seq + len;
                    s = window_slot(next_seq);
                    while (win_valid[s])
                    begin
                        add_result(KIND_DELIVER, win_handle[s], win_nbytes[s], '0, 1'b0);
                        next_seq     = next_seq + win_nbytes[s];
                        win_valid[s] = 1'b0;
                        s = window_slot(next_seq);
                    end
                end
                else if (seq > next_seq)
                begin
                    s = window_slot(seq);
                    if (!win_valid[s])
                    begin
                        win_valid[s]  = 1'b1;
                        win_handle[s] = handle;
                        win_nbytes[s] = len;
                    end
                end
            end
            CMD_FIN:
            begin
                session_up = 1'b0;
                for (int i = 0; i < WINDOW_SLOTS; i++)
                    win_valid[i] = 1'b0;
                add_result(KIND_ACK, '0, '0, seq + 32'd1, 1'b1);
                return packet_results.size();
            end
            default:
                return 0;
        endcase
        add_result(KIND_ACK, '0, '0, next_seq, 1'b1);
        return packet_results.size();
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one packet and hold it until the beat is taken. Called and left
    // at a falling edge; valid stays high on return so back-to-back beats
    // never drop it. Callers lower valid themselves before any pause.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] seq,
                             input logic [LEN_W-1:0] len, input logic [REF_W-1:0] handle,
                             input logic typed, input int n_typed,
                             input logic [SEQ_W-1:0] typed_ack);
        int produced;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid       = 1'b1;
        command        = cmd;
        seq_number     = seq;
        payload_length = len;
        payload_ref    = handle;
        do
            @(posedge clk);
        while (!in_ready);
        produced = reorder_and_ack(cmd, seq, len, handle);
        if (typed)
        begin
            // a typed row is either silent or a single ack
            if (n_typed != 0)
            begin
                head.kind   = KIND_ACK;
                head.handle = '0;
                head.nbytes = '0;
                head.ack    = typed_ack;
                head.last   = 1'b1;
                awaited_results.push_back(head);
            end
        end
        else
        begin
            foreach (packet_results[i])
                awaited_results.push_back(packet_results[i]);
        end
        if (produced > 0)
            counted_items++;
        @(negedge clk);
    endtask

    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] seq,
                         input logic [LEN_W-1:0] len, input logic [REF_W-1:0] handle);
        send_item(cmd, seq, len, handle, 1'b0, 0, '0);
    endtask

    // Hold the sender until every awaited result has been taken.
    task automatic wait_drained();
        while (awaited_results.size() != 0)
            @(negedge clk);
    endtask

    // One transfer: a start, one or more windows of packets in shuffled order
    // with some retransmissions, then usually a fin. A broken transfer drops
    // packets so gaps stay in the window, and may end without a fin.
    task automatic play_session(input bit broken);
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] sq [10];
        logic [LEN_W-1:0] ln [10];
        logic [REF_W-1:0] hd [10];
        int               order [10];
        int               pick, n, nblk, j, tmp;
        bit               full;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            base = $urandom;
        else if (pick < 60)
            base = 32'hFFFF_FFFF - $urandom_range(0, 12000);   // cross the wrap
        else
            base = $urandom & 32'hFFFF_FC00;                    // block aligned
        offer(CMD_START, base, LEN_W'($urandom_range(0, 2047)), REF_W'($urandom));
        nblk = $urandom_range(1, 3);
        for (int b = 0; b < nblk; b++)
        begin
            // full blocks give one packet per slot, so a window of nine with
            // the head last fills every slot and drains them all at once
            full = ($urandom_range(0, 99) < 65);
            n    = full ? $urandom_range(1, 9) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                if (full)
                    ln[i] = ($urandom_range(0, 99) < 10) ?
                            LEN_W'($urandom_range(1024, 2047)) : MAX_LEN;
                else
                    ln[i] = LEN_W'($urandom_range(0, 1024));
                sq[i]    = base;
                hd[i]    = REF_W'($urandom);
                base     = base + ((ln[i] > MAX_LEN) ? MAX_LEN : ln[i]);
                order[i] = i;
            end
            for (int i = n - 1; i > 0; i--)
            begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            if (full && $urandom_range(0, 99) < 40)
            begin
                // move the head of the window to the back
                for (int i = 0; i < n; i++)
                begin
                    if (order[i] == 0)
                    begin
                        order[i]     = order[n - 1];
                        order[n - 1] = 0;
                    end
                end
            end
            for (int k = 0; k < n; k++)
            begin
                if (broken && $urandom_range(0, 99) < 25)
                    continue;
                offer(CMD_DATA, sq[order[k]], ln[order[k]], hd[order[k]]);
                if ($urandom_range(0, 99) < 15)
                begin
                    j = order[$urandom_range(0, k)];
                    offer(CMD_DATA, sq[j], ln[j], hd[j]);
                end
            end
        end
        if (broken)
        begin
            if ($urandom_range(0, 99) < 50)
                offer(CMD_FIN, $urandom, LEN_W'($urandom_range(0, 2047)), REF_W'($urandom));
        end
        else if ($urandom_range(0, 99) < 80)
        begin
            offer(CMD_FIN, base - 32'd1, '0, '0);
        end
    endtask

    // Random traffic until the given number of result-producing items went in.
    task automatic run_traffic(input int target);
        int goal;
        int pick;
        goal = counted_items + target;
        while (counted_items < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                play_session(1'b0);
            else if (pick < 85)
                offer(CMD_W'($urandom_range(0, 3)), $urandom,
                      LEN_W'($urandom_range(0, 2047)), REF_W'($urandom));
            else
                play_session(1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // Drive ready at the falling edge: a forced hold-off first, counted here,
    // otherwise random stalls at the current rate.
    always @(negedge clk)
    begin
        if (sink_hold_left > 0)
        begin
            out_ready = 1'b0;
            sink_hold_left--;
        end
        else
        begin
            out_ready = ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    function automatic int field_differs(input string name, input logic [SEQ_W-1:0] want,
                                         input logic [SEQ_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Compare each result beat with the oldest awaited result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: kind %0d ref 0x%0h len %0d ack 0x%0h last %0d",
                       kind, out_ref, out_length, ack_number, last);
                mismatches++;
            end
            else
            begin
                head = awaited_results.pop_front();
                if (field_differs("kind", SEQ_W'(head.kind), SEQ_W'(kind))
                    + field_differs("out_ref", SEQ_W'(head.handle), SEQ_W'(out_ref))
                    + field_differs("out_length", SEQ_W'(head.nbytes), SEQ_W'(out_length))
                    + field_differs("ack_number", head.ack, ack_number)
                    + field_differs("last", SEQ_W'(head.last), SEQ_W'(last)) != 0)
                    mismatches++;
            end
        end
    end

    // Hang detector: count cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_START;
        seq_number     = '0;
        payload_length = '0;
        payload_ref    = '0;
        out_ready      = 1'b0;
        mismatches     = 0;
        counted_items  = 0;
        quiet_cycles   = 0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        sink_hold_left = 0;
        next_seq       = '0;
        session_up     = 1'b0;
        for (int i = 0; i < WINDOW_SLOTS; i++)
        begin
            win_valid[i]  = 1'b0;
            win_handle[i] = '0;
            win_nbytes[i] = '0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Scripted opening with mild idling on both sides.
        src_idle_pct  = 20;
        snk_stall_pct = 20;
        for (int i = 0; i < N_SCRIPT; i++)
            send_item(script[i].cmd, script[i].seq, script[i].nbytes, script[i].handle,
                      script[i].typed, int'(script[i].n_typed), script[i].typed_ack);
        in_valid = 1'b0;
        wait_drained();

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 71; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 71; end
                default: begin src_idle_pct = 27; snk_stall_pct = 27; end
            endcase
            // back-pressure: hold the receiver off while traffic keeps coming
            if (phase == 0)
                sink_hold_left = LONG_HOLD;
            run_traffic(ITEMS_PER_PHASE);
            // pause the sender until every awaited result is out
            in_valid = 1'b0;
            wait_drained();
        end

        // Keep watching for stray results before the verdict.
        snk_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
